// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Macros for concurrent assertions in the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rbcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbcc_pkg
// Types, codes and the CRC-32 byte step of the record body CRC checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbcc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    REGION_SCOPE  = 2'd0,
    REGION_KEY    = 2'd1,
    REGION_STORED = 2'd2
  } region_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_NO_OPEN  = 2'd2
  } status_e;

  // One byte of a reflected CRC-32, fully unrolled.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/record_body_crc_checker.sv =====
// ----------------------------------------------------------------------------
// record_body_crc_checker
// Streaming reflected CRC-32 verifier and region router for a record body.
// ----------------------------------------------------------------------------
// A request is held in the input register, then passes the CRC and region
// logic that writes the output register. The byte step is an unrolled
// 8-bit CRC update beside the 34-bit length compares, so a new request is
// taken every cycle unless the output is stalled while both stages hold a
// request. A start request opens a record and gives no result unless all
// three lengths are zero; every body byte request gives exactly one result.
// A new start abandons any open record.
`timescale 1ns / 1ps
`default_nettype none

module record_body_crc_checker
  import rbcc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [31:0] scope_len_i,
  input  wire logic [31:0] key_len_i,
  input  wire logic [31:0] stored_len_i,
  input  wire logic [31:0] expected_crc_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       region_o,
  output logic [31:0]      region_offset_o,
  output logic             last_o,
  output logic [1:0]       status_o
);

  // Input register.
  logic        s1_valid_q;
  logic        s1_cmd_q;
  logic [31:0] s1_scope_q, s1_key_q, s1_stored_q, s1_crc_q;
  logic [7:0]  s1_byte_q;

  // Record state.
  logic [31:0] crc_acc_q, crc_acc_d;
  logic [33:0] byte_pos_q, byte_pos_d;
  logic [31:0] scope_limit_q, scope_limit_d;
  logic [32:0] key_limit_q, key_limit_d;
  logic [33:0] body_limit_q, body_limit_d;
  logic [31:0] crc_target_q, crc_target_d;
  logic        record_open_q, record_open_d;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_byte_q, out_byte_d;
  region_e     region_q, region_d;
  logic [31:0] offset_q, offset_d;
  logic        last_q, last_d;
  status_e     status_q, status_d;
  logic        emit;

  logic        advance, fire, in_take;
  logic [32:0] key_sum;
  logic [33:0] body_sum;
  logic [31:0] crc_next;
  logic [33:0] pos_next;
  logic [33:0] off_key, off_stored;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q    <= command_i;
      s1_scope_q  <= scope_len_i;
      s1_key_q    <= key_len_i;
      s1_stored_q <= stored_len_i;
      s1_crc_q    <= expected_crc_i;
      s1_byte_q   <= data_byte_i;
    end
  end

  assign key_sum    = {1'b0, s1_scope_q} + {1'b0, s1_key_q};
  assign body_sum   = {1'b0, key_sum} + {2'b00, s1_stored_q};
  assign crc_next   = crc32_byte(crc_acc_q, s1_byte_q);
  assign pos_next   = byte_pos_q + 34'd1;
  assign off_key    = byte_pos_q - {2'b00, scope_limit_q};
  assign off_stored = byte_pos_q - {1'b0, key_limit_q};

  always_comb begin
    crc_acc_d     = crc_acc_q;
    byte_pos_d    = byte_pos_q;
    scope_limit_d = scope_limit_q;
    key_limit_d   = key_limit_q;
    body_limit_d  = body_limit_q;
    crc_target_d  = crc_target_q;
    record_open_d = record_open_q;
    emit          = 1'b0;
    out_byte_d    = s1_byte_q;
    region_d      = REGION_SCOPE;
    offset_d      = 32'd0;
    last_d        = 1'b0;
    status_d      = STATUS_OK;

    if (s1_cmd_q == CMD_START) begin
      scope_limit_d = s1_scope_q;
      key_limit_d   = key_sum;
      body_limit_d  = body_sum;
      crc_target_d  = s1_crc_q;
      crc_acc_d     = CRC_ONES;
      byte_pos_d    = 34'd0;
      out_byte_d    = 8'd0;
      // The CRC of an empty body is zero.
      if ((s1_scope_q | s1_key_q | s1_stored_q) == 32'd0) begin
        record_open_d = 1'b0;
        emit          = 1'b1;
        last_d        = 1'b1;
        status_d      = (s1_crc_q != 32'd0) ? STATUS_MISMATCH : STATUS_OK;
      end else begin
        record_open_d = 1'b1;
      end
    end else if (!record_open_q) begin
      emit     = 1'b1;
      status_d = STATUS_NO_OPEN;
    end else begin
      emit       = 1'b1;
      crc_acc_d  = crc_next;
      byte_pos_d = pos_next;
      if (byte_pos_q < {2'b00, scope_limit_q}) begin
        region_d = REGION_SCOPE;
        offset_d = byte_pos_q[31:0];
      end else if (byte_pos_q < {1'b0, key_limit_q}) begin
        region_d = REGION_KEY;
        offset_d = off_key[31:0];
      end else begin
        region_d = REGION_STORED;
        offset_d = off_stored[31:0];
      end
      if (pos_next >= body_limit_q) begin
        last_d        = 1'b1;
        record_open_d = 1'b0;
        status_d      = ((crc_next ^ CRC_ONES) != crc_target_q) ? STATUS_MISMATCH
                                                                 : STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_acc_q     <= CRC_ONES;
      byte_pos_q    <= '0;
      scope_limit_q <= '0;
      key_limit_q   <= '0;
      body_limit_q  <= '0;
      crc_target_q  <= '0;
      record_open_q <= 1'b0;
    end else if (fire) begin
      crc_acc_q     <= crc_acc_d;
      byte_pos_q    <= byte_pos_d;
      scope_limit_q <= scope_limit_d;
      key_limit_q   <= key_limit_d;
      body_limit_q  <= body_limit_d;
      crc_target_q  <= crc_target_d;
      record_open_q <= record_open_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_byte_q <= out_byte_d;
      region_q   <= region_d;
      offset_q   <= offset_d;
      last_q     <= last_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign region_o        = region_q;
  assign region_offset_o = offset_q;
  assign last_o          = last_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rbcc_checker.sv =====
// ----------------------------------------------------------------------------
// rbcc_checker
// Port-level assertions for the record body CRC checker, bound to its top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rbcc_checker
  import rbcc_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic [1:0]  region_o,
  input wire logic [31:0] region_offset_o,
  input wire logic        last_o,
  input wire logic [1:0]  status_o
);

  logic out_hold;
  assign out_hold = out_valid_o && out_stall_i;

  // A clock edge under reset leaves the output register empty.
  `ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

  // The input side only backs up when the output side is full and stalled.
  `ASSERT_CLKD(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_hold)

  // A mismatch is only reported on the final result of a record.
  `ASSERT_CLKD(a_mismatch_last, clk_i, rst_ni,
               (out_valid_o && status_o == STATUS_MISMATCH) |-> last_o)

  // A byte without an open record carries no region information.
  `ASSERT_CLKD(a_no_open_fields, clk_i, rst_ni,
               (out_valid_o && status_o == STATUS_NO_OPEN) |->
               (!last_o && region_o == REGION_SCOPE && region_offset_o == 32'd0))

  // A stalled request keeps its payload.
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni,
               out_hold |=> (out_valid_o && $stable(out_byte_o) && $stable(region_o)
                             && $stable(region_offset_o) && $stable(last_o)
                             && $stable(status_o)))

endmodule

bind record_body_crc_checker rbcc_checker u_rbcc_checker (.*);

`default_nettype wire

// ===== sim/record_body_crc_checker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_body_crc_checker_tb
// Drives start and body byte requests into the record body CRC checker and
// checks every result against a cycle-free predictor of the region routing
// and the reflected CRC-32. Directed tests cover empty bodies, bytes with no
// open record, region walks, restarts and large lengths. Random tests follow
// with back pressure, random idling on both sides and a steady final stretch.
// ----------------------------------------------------------------------------

module record_body_crc_checker_tb;
  import rbcc_pkg::*;

  localparam int HOLD_CYCLES = 64;

  typedef struct packed {
    logic [7:0]  out_byte;
    region_e     region;
    logic [31:0] offset;
    logic        last;
    status_e     status;
  } body_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  command_e    command = CMD_START;
  logic [31:0] scope_len = '0;
  logic [31:0] key_len = '0;
  logic [31:0] stored_len = '0;
  logic [31:0] expected_crc = '0;
  logic [7:0]  data_byte = '0;
  logic        out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [1:0]  region;
  logic [31:0] region_offset;
  logic        last;
  logic [1:0]  status;

  // Predictor state.
  logic [31:0] crc_run = CRC_ONES;
  logic [33:0] body_pos = '0;
  logic [31:0] scope_end = '0;
  logic [32:0] key_end = '0;
  logic [33:0] body_end = '0;
  logic [31:0] crc_goal = '0;
  logic        rec_open = 1'b0;

  body_result_t pending_results[$];
  int mismatches = 0;
  int items_sent = 0;

  bit idle_enable = 1'b1;
  int gap_pct = 20;
  int stall_pct = 15;
  int stall_left = 0;
  int stall_epoch = 0;
  bit hold_request = 1'b0;
  bit hold_active = 1'b0;

  record_body_crc_checker dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .scope_len_i    (scope_len),
    .key_len_i      (key_len),
    .stored_len_i   (stored_len),
    .expected_crc_i (expected_crc),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .region_o       (region),
    .region_offset_o(region_offset),
    .last_o         (last),
    .status_o       (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bit-serial form of the reflected CRC-32: one data bit per shift.
  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void predict_request(input command_e cmd, input logic [31:0] s,
                                          input logic [31:0] k, input logic [31:0] t,
                                          input logic [31:0] goal, input logic [7:0] b);
    body_result_t r;
    r.out_byte = b;
    r.region = REGION_SCOPE;
    r.offset = '0;
    r.last = 1'b0;
    r.status = STATUS_OK;
    if (cmd == CMD_START) begin
      scope_end = s;
      key_end = {1'b0, s} + {1'b0, k};
      body_end = {2'b00, s} + {2'b00, k} + {2'b00, t};
      crc_goal = goal;
      crc_run = CRC_ONES;
      body_pos = '0;
      rec_open = (body_end != '0);
      if (!rec_open) begin
        r.out_byte = 8'h00;
        r.last = 1'b1;
        r.status = (goal != 32'd0) ? STATUS_MISMATCH : STATUS_OK;
        pending_results.push_back(r);
      end
    end else if (!rec_open) begin
      r.status = STATUS_NO_OPEN;
      pending_results.push_back(r);
    end else begin
      crc_run = crc_fold(crc_run, b);
      if (body_pos < {2'b00, scope_end}) begin
        r.region = REGION_SCOPE;
        r.offset = body_pos[31:0];
      end else if (body_pos < {1'b0, key_end}) begin
        r.region = REGION_KEY;
        r.offset = 32'(body_pos - {2'b00, scope_end});
      end else begin
        r.region = REGION_STORED;
        r.offset = 32'(body_pos - {1'b0, key_end});
      end
      body_pos = body_pos + 34'd1;
      if (body_pos >= body_end) begin
        r.last = 1'b1;
        r.status = ((~crc_run) != crc_goal) ? STATUS_MISMATCH : STATUS_OK;
        rec_open = 1'b0;
      end
      pending_results.push_back(r);
    end
  endfunction

  // Offers one request and holds it until the block takes it.
  task automatic send_request(input command_e cmd, input logic [31:0] s,
                              input logic [31:0] k, input logic [31:0] t,
                              input logic [31:0] goal, input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    scope_len    <= s;
    key_len      <= k;
    stored_len   <= t;
    expected_crc <= goal;
    data_byte    <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(cmd, s, k, t, goal, b);
    items_sent++;
  endtask

  task automatic send_start(input logic [31:0] s, input logic [31:0] k,
                            input logic [31:0] t, input logic [31:0] goal);
    send_request(CMD_START, s, k, t, goal, 8'($urandom()));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(CMD_BYTE, $urandom(), $urandom(), $urandom(), $urandom(), b);
  endtask

  // Sends a record with random body bytes; the CRC may be spoiled and the
  // body may be cut short so that the next request abandons the record.
  task automatic send_record(input int s, input int k, input int t,
                             input bit corrupt, input bit cut_short);
    logic [7:0]  body[$];
    logic [31:0] crc;
    int          stop;
    crc = CRC_ONES;
    for (int i = 0; i < s + k + t; i++) begin
      body.push_back(8'($urandom()));
      crc = crc_fold(crc, body[i]);
    end
    crc = ~crc;
    if (corrupt) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    stop = cut_short ? $urandom_range(0, body.size()) : body.size();
    send_start(s, k, t, crc);
    for (int i = 0; i < stop; i++) send_byte(body[i]);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_records();
    send_start(32'd0, 32'd0, 32'd0, 32'd0);
    send_start(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_start(32'd0, 32'd0, 32'd0, 32'd1);
    drain_results();
  endtask

  task automatic test_orphan_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    drain_results();
  endtask

  task automatic test_region_walk();
    send_record(2, 2, 2, 1'b0, 1'b0);
    drain_results();
  endtask

  task automatic test_restart();
    send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_start(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_byte(8'h3C);
    // A single zero byte has the known CRC-32 D202EF8D.
    send_start(32'd0, 32'd0, 32'd1, 32'hD202_EF8D);
    send_byte(8'h00);
    send_start(32'd0, 32'd0, 32'd1, 32'd0);
    send_byte(8'hFF);
    send_byte(8'h81);
    drain_results();
  endtask

  // The receiver holds off while bytes of a long record keep coming, so the
  // pipeline fills and the input side has to stall.
  task automatic test_backpressure();
    gap_pct = 0;
    send_start(32'd0, 32'd0, 32'hFFFF_FFFF, $urandom());
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom()));
    send_start(32'd0, 32'd0, 32'd0, 32'd0);
    drain_results();
  endtask

  task automatic random_mix(input int target);
    int pick;
    int n;
    while (items_sent < target) begin
      if (idle_enable) begin
        pick = $urandom_range(0, 2);
        gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 9) == 0) begin
          send_record($urandom_range(0, 24), $urandom_range(0, 4), $urandom_range(0, 24),
                      $urandom_range(0, 4) == 0, 1'b0);
        end else begin
          send_record($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
                      $urandom_range(0, 4) == 0, 1'b0);
        end
      end else if (pick < 80) begin
        send_record($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5),
                    1'b0, 1'b1);
      end else if (pick < 88) begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom()));
      end else if (pick < 95) begin
        send_start($urandom(), $urandom(), $urandom(), $urandom());
        n = $urandom_range(0, 4);
        repeat (n) send_byte(8'($urandom()));
      end else begin
        send_start(32'd0, 32'd0, 32'd0, ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom());
      end
    end
  endtask

  task automatic test_random_records();
    random_mix(1300);
    drain_results();
  endtask

  task automatic test_steady_stream();
    idle_enable = 1'b0;
    gap_pct = 0;
    random_mix(1550);
  endtask

  // Output stall in random bursts; the rate changes now and then so that
  // stretches without stalls occur too.
  always @(negedge clk) begin
    stall_epoch++;
    if (stall_epoch % 256 == 0) stall_pct = $urandom_range(0, 2) * 15;
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_enable && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 8);
    end
    out_stall <= (stall_left != 0) || hold_active;
  end

  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  always @(posedge clk) begin
    body_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: byte %h region %0d offset %h last %b status %0d",
                   out_byte, region, region_offset, last, status);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.out_byte || region !== want.region ||
            region_offset !== want.offset || last !== want.last ||
            status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: byte %h/%h region %0d/%0d offset %h/%h last %b/%b status %0d/%0d",
                     want.out_byte, out_byte, want.region, region, want.offset,
                     region_offset, want.last, last, want.status, status);
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_records();
    test_orphan_bytes();
    test_region_walk();
    test_restart();
    test_backpressure();
    test_random_records();
    test_steady_stream();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
